// ===== hdl/uff_pkg.sv =====
`default_nettype none
package uff_pkg;

    typedef enum logic [1:0] {
        MODE_RX_LINE   = 2'd0,
        MODE_APP_READ  = 2'd1,
        MODE_APP_WRITE = 2'd2,
        MODE_TX_READY  = 2'd3
    } mode_t;

    localparam int          ADDR_W       = 4;
    localparam logic [1:0]  REG_FLOW     = 2'd0;
    localparam logic [1:0]  REG_HIGH     = 2'd1;
    localparam logic [1:0]  REG_LOW      = 2'd2;

    localparam logic        FLOW_RESET   = 1'b1;
    localparam logic [5:0]  HIGH_RESET   = 6'd56;
    localparam logic [5:0]  LOW_RESET    = 6'd8;
    localparam logic [15:0] REFUSALS_MAX = 16'hFFFF;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ring_stat_t;

endpackage
`default_nettype wire

// ===== hdl/uff_ram.sv =====
`default_nettype none
module uff_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/uff_ring.sv =====
`default_nettype none
module uff_ring #(
    parameter  int DEPTH = 64,
    localparam int PW    = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire uff_pkg::ring_cmd_t   cmd,
    input  wire logic [7:0]           wdata,
    output logic      [7:0]           rdata,
    output uff_pkg::ring_stat_t       stat,
    output logic      [PW-1:0]        count
);

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic          push_ok, pop_ok;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [PW-1:0] ring_count(input logic [PW-1:0] h,
                                                 input logic [PW-1:0] t);
        logic [PW:0] s;
        if (h >= t)
        begin
            s = {1'b0, h} - {1'b0, t};
        end
        else
        begin
            s = {1'b0, h} + (PW+1)'(DEPTH) - {1'b0, t};
        end
        return s[PW-1:0];
    endfunction

    always_comb
    begin
        stat.empty = (head_reg == tail_reg);
        stat.full  = (next_ptr(head_reg) == tail_reg);
        push_ok    = cmd.push & ~stat.full;
        pop_ok     = cmd.pop & ~stat.empty;
        head_next  = push_ok ? next_ptr(head_reg) : head_reg;
        tail_next  = pop_ok ? next_ptr(tail_reg) : tail_reg;
        count      = ring_count(head_reg, tail_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    uff_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (head_reg),
        .wdata (wdata),
        .re    (pop_ok),
        .raddr (tail_reg),
        .rdata (rdata)
    );

endmodule
`default_nettype wire

// ===== hdl/uff_rts.sv =====
`default_nettype none
module uff_rts #(
    parameter  int DEPTH = 64,
    localparam int PW    = $clog2(DEPTH),
    localparam int CW    = (PW > 6) ? PW : 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          line_beat,
    input  wire logic          line_stored,
    input  wire logic          read_beat,
    input  wire logic          flow_enable,
    input  wire logic [5:0]    high_water,
    input  wire logic [5:0]    low_water,
    input  wire logic [PW-1:0] rx_count,
    output logic               rts
);

    logic          rts_reg, rts_next;
    logic          above_high, below_low;
    logic [PW-1:0] count_next;

    always_comb
    begin
        priority if (line_stored)
        begin
            count_next = rx_count + PW'(1);
        end
        else if (read_beat)
        begin
            count_next = rx_count - PW'(1);
        end
        else
        begin
            count_next = rx_count;
        end
        above_high = CW'(count_next) > CW'(high_water);
        below_low  = CW'(count_next) < CW'(low_water);
        priority if (flow_enable && line_beat && above_high)
        begin
            rts_next = 1'b1;
        end
        else if (flow_enable && read_beat && below_low)
        begin
            rts_next = 1'b0;
        end
        else
        begin
            rts_next = rts_reg;
        end
        rts = rts_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rts_reg <= 1'b0;
        end
        else
        begin
            rts_reg <= rts_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/uff_top_stub.sv =====
`default_nettype none
module uff_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [uff_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             flow_enable,
    output logic      [5:0]                  high_water,
    output logic      [5:0]                  low_water
);

    logic       flow_reg, flow_next;
    logic [5:0] high_reg, high_next;
    logic [5:0] low_reg,  low_next;
    logic       wr_beat;

    always_comb
    begin
        wr_beat   = psel & penable & pwrite;
        flow_next = flow_reg;
        high_next = high_reg;
        low_next  = low_reg;
        prdata    = '0;
        unique case (paddr[3:2])
            uff_pkg::REG_FLOW:
            begin
                prdata = {31'd0, flow_reg};
                if (wr_beat)
                begin
                    flow_next = pwdata[0];
                end
            end
            uff_pkg::REG_HIGH:
            begin
                prdata = {26'd0, high_reg};
                if (wr_beat)
                begin
                    high_next = pwdata[5:0];
                end
            end
            uff_pkg::REG_LOW:
            begin
                prdata = {26'd0, low_reg};
                if (wr_beat)
                begin
                    low_next = pwdata[5:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
        flow_enable = flow_reg;
        high_water  = high_reg;
        low_water   = low_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_reg <= uff_pkg::FLOW_RESET;
            high_reg <= uff_pkg::HIGH_RESET;
            low_reg  <= uff_pkg::LOW_RESET;
        end
        else
        begin
            flow_reg <= flow_next;
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/uart_fifo_rts_flow_control.sv =====
`default_nettype none
// UART receive/transmit FIFO pair with software RTS flow control. One event
// (line byte, application read, application write, transmitter ready) is
// taken per clock; busy is never raised. Each event's result appears with
// done high for exactly one cycle, in the cycle after the event is
// accepted, and must be captured then: there is no way to stall it. Read
// data comes from the registered read port of each ring's RAM. Each ring holds
// RING_DEPTH-1 bytes; rx_count and tx_count report the low six bits of the
// fill level. The RAMs need no clearing after reset.
module uart_fifo_rts_flow_control #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [uff_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  mode,
    input  wire logic [7:0]                  data_in,
    output logic                             done,
    output logic      [7:0]                  data_out,
    output logic                             data_valid,
    output logic                             accepted,
    output logic                             rts_asserted,
    output logic                             tx_irq_enable,
    output logic      [5:0]                  rx_count,
    output logic      [5:0]                  tx_count,
    output logic      [15:0]                 refused_count
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = (PW > 6) ? PW : 6;

    logic                 flow_enable;
    logic [5:0]           high_water, low_water;
    logic                 beat;
    uff_pkg::mode_t       mode_e;
    uff_pkg::ring_cmd_t   rx_cmd, tx_cmd;
    uff_pkg::ring_stat_t  rx_stat, tx_stat;
    logic [7:0]           rx_rdata, tx_rdata;
    logic [PW-1:0]        rx_cnt, tx_cnt;
    logic [CW-1:0]        rx_cnt_w, tx_cnt_w;

    logic        done_reg, done_next;
    logic        valid_reg, valid_next;
    logic        acc_reg, acc_next;
    logic        sel_tx_reg, sel_tx_next;
    logic        irq_reg, irq_next;
    logic [15:0] refusals_reg, refusals_next;

    uff_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .flow_enable (flow_enable),
        .high_water  (high_water),
        .low_water   (low_water)
    );

    always_comb
    begin
        busy          = 1'b0;
        pready        = 1'b1;
        beat          = start & ~busy;
        mode_e        = uff_pkg::mode_t'(mode);
        rx_cmd        = '0;
        tx_cmd        = '0;
        done_next     = beat;
        valid_next    = 1'b0;
        acc_next      = 1'b0;
        sel_tx_next   = sel_tx_reg;
        irq_next      = irq_reg;
        refusals_next = refusals_reg;
        if (beat)
        begin
            unique case (mode_e)
                uff_pkg::MODE_RX_LINE:
                begin
                    rx_cmd.push = 1'b1;
                    acc_next    = ~rx_stat.full;
                end
                uff_pkg::MODE_APP_READ:
                begin
                    rx_cmd.pop  = 1'b1;
                    valid_next  = ~rx_stat.empty;
                    sel_tx_next = 1'b0;
                end
                uff_pkg::MODE_APP_WRITE:
                begin
                    tx_cmd.push = 1'b1;
                    acc_next    = ~tx_stat.full;
                    if (!tx_stat.full)
                    begin
                        irq_next = 1'b1;
                    end
                    else if (refusals_reg != uff_pkg::REFUSALS_MAX)
                    begin
                        refusals_next = refusals_reg + 16'd1;
                    end
                end
                uff_pkg::MODE_TX_READY:
                begin
                    tx_cmd.pop  = 1'b1;
                    valid_next  = ~tx_stat.empty;
                    sel_tx_next = 1'b1;
                    if (tx_stat.empty)
                    begin
                        irq_next = 1'b0;
                    end
                end
                default:
                begin
                    rx_cmd = '0;
                end
            endcase
        end
        rx_cnt_w      = CW'(rx_cnt);
        tx_cnt_w      = CW'(tx_cnt);
        done          = done_reg;
        data_valid    = valid_reg;
        accepted      = acc_reg;
        data_out      = valid_reg ? (sel_tx_reg ? tx_rdata : rx_rdata) : 8'd0;
        tx_irq_enable = irq_reg;
        rx_count      = rx_cnt_w[5:0];
        tx_count      = tx_cnt_w[5:0];
        refused_count = refusals_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            valid_reg    <= 1'b0;
            acc_reg      <= 1'b0;
            sel_tx_reg   <= 1'b0;
            irq_reg      <= 1'b0;
            refusals_reg <= '0;
        end
        else
        begin
            done_reg     <= done_next;
            valid_reg    <= valid_next;
            acc_reg      <= acc_next;
            sel_tx_reg   <= sel_tx_next;
            irq_reg      <= irq_next;
            refusals_reg <= refusals_next;
        end
    end

    uff_ring #(
        .DEPTH (RING_DEPTH)
    ) u_rx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rx_cmd),
        .wdata (data_in),
        .rdata (rx_rdata),
        .stat  (rx_stat),
        .count (rx_cnt)
    );

    uff_ring #(
        .DEPTH (RING_DEPTH)
    ) u_tx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tx_cmd),
        .wdata (data_in),
        .rdata (tx_rdata),
        .stat  (tx_stat),
        .count (tx_cnt)
    );

    uff_rts #(
        .DEPTH (RING_DEPTH)
    ) u_rts (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_beat   (rx_cmd.push),
        .line_stored (rx_cmd.push & ~rx_stat.full),
        .read_beat   (rx_cmd.pop & ~rx_stat.empty),
        .flow_enable (flow_enable),
        .high_water  (high_water),
        .low_water   (low_water),
        .rx_count    (rx_cnt),
        .rts         (rts_asserted)
    );

`ifndef SYNTH
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result beat missing after accepted event");

    a_valid_acc_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(data_valid && accepted))
        else $error("data_valid and accepted both set");

    a_refusal_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(refused_count) |->
            $past(start && mode == uff_pkg::MODE_APP_WRITE && tx_stat.full))
        else $error("refusal count moved without a refused write");

    a_rts_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rts_asserted) |-> $past(start && mode == uff_pkg::MODE_RX_LINE))
        else $error("RTS rose without a line byte");
`endif

endmodule
`default_nettype wire

// ===== tb/uart_fifo_rts_flow_control_tb.sv =====
module uart_fifo_rts_flow_control_tb;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_EVENTS   = 175;

    typedef struct packed {
        logic [7:0]  data_out;
        logic        data_valid;
        logic        accepted;
        logic        rts;
        logic        tx_irq;
        logic [5:0]  rx_count;
        logic [5:0]  tx_count;
        logic [15:0] refused;
    } uart_status_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [uff_pkg::ADDR_W-1:0]   paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         start = 1'b0;
    logic                         busy;
    logic [1:0]                   mode = uff_pkg::MODE_RX_LINE;
    logic [7:0]                   data_in = '0;
    logic                         done;
    logic [7:0]                   data_out;
    logic                         data_valid;
    logic                         accepted;
    logic                         rts_asserted;
    logic                         tx_irq_enable;
    logic [5:0]                   rx_count;
    logic [5:0]                   tx_count;
    logic [15:0]                  refused_count;

    // mirror of the block state
    logic [7:0]  rx_ring [64];
    logic [7:0]  tx_ring [64];
    logic [5:0]  rx_head = '0;
    logic [5:0]  rx_tail = '0;
    logic [5:0]  tx_head = '0;
    logic [5:0]  tx_tail = '0;
    logic        rts_model = 1'b0;
    logic        irq_model = 1'b0;
    logic [15:0] refusals_model = '0;
    logic        cfg_flow = uff_pkg::FLOW_RESET;
    logic [5:0]  cfg_high = uff_pkg::HIGH_RESET;
    logic [5:0]  cfg_low = uff_pkg::LOW_RESET;

    uart_status_t status_q [$];
    int mismatches = 0;
    int beats_checked = 0;
    int event_count [4] = '{0, 0, 0, 0};
    int config_writes = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int traffic_idx = 0;
    bit bursty = 1'b1;

    uart_fifo_rts_flow_control dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [5:0] rx_level();
        return rx_head - rx_tail;
    endfunction

    function automatic logic [5:0] tx_level();
        return tx_head - tx_tail;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic uart_status_t apply_event(uff_pkg::mode_t m, logic [7:0] d);
        uart_status_t r;
        logic [5:0] nxt;
        r = '0;
        case (m)
            uff_pkg::MODE_RX_LINE:
            begin
                nxt = rx_head + 6'd1;
                if (nxt != rx_tail)
                begin
                    rx_ring[rx_head] = d;
                    rx_head = nxt;
                    r.accepted = 1'b1;
                end
                if (cfg_flow && rx_level() > cfg_high)
                    rts_model = 1'b1;
            end
            uff_pkg::MODE_APP_READ:
            begin
                if (rx_head != rx_tail)
                begin
                    r.data_out = rx_ring[rx_tail];
                    r.data_valid = 1'b1;
                    rx_tail = rx_tail + 6'd1;
                    if (cfg_flow && rx_level() < cfg_low)
                        rts_model = 1'b0;
                end
            end
            uff_pkg::MODE_APP_WRITE:
            begin
                nxt = tx_head + 6'd1;
                if (nxt != tx_tail)
                begin
                    tx_ring[tx_head] = d;
                    tx_head = nxt;
                    irq_model = 1'b1;
                    r.accepted = 1'b1;
                end
                else if (refusals_model != uff_pkg::REFUSALS_MAX)
                begin
                    refusals_model = refusals_model + 16'd1;
                end
            end
            default:
            begin
                if (tx_head != tx_tail)
                begin
                    r.data_out = tx_ring[tx_tail];
                    r.data_valid = 1'b1;
                    tx_tail = tx_tail + 6'd1;
                end
                else
                begin
                    irq_model = 1'b0;
                end
            end
        endcase
        r.rts = rts_model;
        r.tx_irq = irq_model;
        r.rx_count = rx_level();
        r.tx_count = tx_level();
        r.refused = refusals_model;
        event_count[m]++;
        return r;
    endfunction

    always @(posedge clk)
    begin : check_results
        uart_status_t want;
        if (rst_n && done)
        begin
            if (status_q.size() == 0)
            begin
                $error("result beat with no expected status pending");
                mismatches++;
            end
            else
            begin
                want = status_q.pop_front();
                beats_checked++;
                check_field("data_out", 32'(want.data_out), 32'(data_out));
                check_field("data_valid", 32'(want.data_valid), 32'(data_valid));
                check_field("accepted", 32'(want.accepted), 32'(accepted));
                check_field("rts_asserted", 32'(want.rts), 32'(rts_asserted));
                check_field("tx_irq_enable", 32'(want.tx_irq), 32'(tx_irq_enable));
                check_field("rx_count", 32'(want.rx_count), 32'(rx_count));
                check_field("tx_count", 32'(want.tx_count), 32'(tx_count));
                check_field("refused_count", 32'(want.refused), 32'(refused_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_event(input uff_pkg::mode_t m, input logic [7:0] d);
        int gap;
        if (bursty && burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        start <= 1'b1;
        mode <= m;
        data_in <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        status_q.push_back(apply_event(m, d));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input int idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= uff_pkg::ADDR_W'(4 * idx);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        config_writes++;
        case (idx)
            uff_pkg::REG_FLOW: cfg_flow = value[0];
            uff_pkg::REG_HIGH: cfg_high = value[5:0];
            uff_pkg::REG_LOW:  cfg_low = value[5:0];
            default:  ;
        endcase
    endtask

    task automatic reg_read(input int idx);
        logic [31:0] want;
        case (idx)
            uff_pkg::REG_FLOW: want = {31'b0, cfg_flow};
            uff_pkg::REG_HIGH: want = {26'b0, cfg_high};
            default:  want = {26'b0, cfg_low};
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= uff_pkg::ADDR_W'(4 * idx);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("prdata", want, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // upper bits carry junk that the block must drop
    task automatic set_config(input logic flow, input logic [5:0] high, input logic [5:0] low);
        logic [31:0] junk;
        wait_idle();
        junk = $urandom();
        reg_write(uff_pkg::REG_FLOW, {junk[31:1], flow});
        junk = $urandom();
        reg_write(uff_pkg::REG_HIGH, {junk[31:6], high});
        junk = $urandom();
        reg_write(uff_pkg::REG_LOW, {junk[31:6], low});
    endtask

    task automatic test_register_access();
        reg_read(uff_pkg::REG_FLOW);
        reg_read(uff_pkg::REG_HIGH);
        reg_read(uff_pkg::REG_LOW);
        set_config(1'b0, 6'd63, 6'd0);
        reg_read(uff_pkg::REG_FLOW);
        reg_read(uff_pkg::REG_HIGH);
        reg_read(uff_pkg::REG_LOW);
        reg_write(uff_pkg::REG_LOW + 1, 32'hFFFF_FFFF);
        reg_read(uff_pkg::REG_FLOW);
        reg_read(uff_pkg::REG_HIGH);
        reg_read(uff_pkg::REG_LOW);
        set_config(uff_pkg::FLOW_RESET, uff_pkg::HIGH_RESET, uff_pkg::LOW_RESET);
        reg_read(uff_pkg::REG_HIGH);
    endtask

    task automatic test_directed_events();
        send_event(uff_pkg::MODE_APP_READ, 8'hFF);
        send_event(uff_pkg::MODE_TX_READY, 8'h00);
        send_event(uff_pkg::MODE_RX_LINE, 8'h00);
        send_event(uff_pkg::MODE_RX_LINE, 8'hFF);
        send_event(uff_pkg::MODE_RX_LINE, 8'hA5);
        send_event(uff_pkg::MODE_APP_WRITE, 8'h00);
        send_event(uff_pkg::MODE_APP_WRITE, 8'hFF);
        send_event(uff_pkg::MODE_APP_WRITE, 8'h5A);
        repeat (4) send_event(uff_pkg::MODE_APP_READ, 8'h5A);
        repeat (4) send_event(uff_pkg::MODE_TX_READY, 8'hA5);
        send_event(uff_pkg::MODE_APP_WRITE, 8'h81);
        send_event(uff_pkg::MODE_TX_READY, 8'h7E);
        send_event(uff_pkg::MODE_TX_READY, 8'h18);
        wait_idle();
    endtask

    // fill past the high mark and into the dropped-byte region, then drain
    task automatic test_rx_overflow_rts();
        repeat (66) send_event(uff_pkg::MODE_RX_LINE, 8'($urandom()));
        repeat (66) send_event(uff_pkg::MODE_APP_READ, 8'($urandom()));
        wait_idle();
    endtask

    task automatic test_flow_control_off();
        set_config(1'b0, uff_pkg::HIGH_RESET, uff_pkg::LOW_RESET);
        repeat (60) send_event(uff_pkg::MODE_RX_LINE, 8'($urandom()));
        set_config(1'b1, uff_pkg::HIGH_RESET, uff_pkg::LOW_RESET);
        send_event(uff_pkg::MODE_RX_LINE, 8'($urandom()));
        set_config(1'b0, uff_pkg::HIGH_RESET, uff_pkg::LOW_RESET);
        repeat (62) send_event(uff_pkg::MODE_APP_READ, 8'($urandom()));
        set_config(1'b1, uff_pkg::HIGH_RESET, uff_pkg::LOW_RESET);
        send_event(uff_pkg::MODE_APP_READ, 8'($urandom()));
        send_event(uff_pkg::MODE_RX_LINE, 8'($urandom()));
        send_event(uff_pkg::MODE_APP_READ, 8'($urandom()));
        wait_idle();
    endtask

    task automatic test_tx_overflow();
        repeat (67) send_event(uff_pkg::MODE_APP_WRITE, 8'($urandom()));
        repeat (66) send_event(uff_pkg::MODE_TX_READY, 8'($urandom()));
        wait_idle();
    endtask

    // each ring alternates between fill-heavy and drain-heavy windows
    task automatic run_traffic(input int events);
        int pick;
        bit rx_fill;
        bit tx_fill;
        uff_pkg::mode_t m;
        for (int i = 0; i < events; i++)
        begin
            rx_fill = ((traffic_idx / 150) % 2) == 0;
            tx_fill = ((traffic_idx / 146) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                m = uff_pkg::mode_t'($urandom_range(0, 3));
            else if (pick < 52)
                m = (($urandom_range(0, 99) < 92) == rx_fill) ?
                    uff_pkg::MODE_RX_LINE : uff_pkg::MODE_APP_READ;
            else
                m = (($urandom_range(0, 99) < 92) == tx_fill) ?
                    uff_pkg::MODE_APP_WRITE : uff_pkg::MODE_TX_READY;
            send_event(m, 8'($urandom()));
            traffic_idx++;
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(PHASE_EVENTS);
        set_config(1'b1, 6'd63, 6'd0);
        run_traffic(PHASE_EVENTS);
        set_config(1'b1, 6'd0, 6'd63);
        run_traffic(PHASE_EVENTS);
        set_config(1'b0, 6'($urandom()), 6'($urandom()));
        run_traffic(PHASE_EVENTS);
        set_config(1'b1, 6'($urandom()), 6'($urandom()));
        wait_idle();
        bursty = 1'b0;
        run_traffic(PHASE_EVENTS);
        bursty = 1'b1;
        set_config(1'b1, 6'd32, 6'd40);
        run_traffic(PHASE_EVENTS);
        wait_idle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_events();
        test_rx_overflow_rts();
        test_flow_control_off();
        test_tx_overflow();
        test_random_traffic();
        wait_idle();
        $display("Events: %0d line bytes, %0d reads, %0d writes, %0d transmitter-ready",
                 event_count[uff_pkg::MODE_RX_LINE], event_count[uff_pkg::MODE_APP_READ],
                 event_count[uff_pkg::MODE_APP_WRITE], event_count[uff_pkg::MODE_TX_READY]);
        $display("%0d status beats checked, %0d register writes", beats_checked, config_writes);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== uart_fifo_rts_flow_control.f =====
hdl/uff_pkg.sv
hdl/uff_ram.sv
hdl/uff_ring.sv
hdl/uff_rts.sv
hdl/uff_top_stub.sv
hdl/uart_fifo_rts_flow_control.sv
tb/uart_fifo_rts_flow_control_tb.sv
